// ===== sv/integer_to_ascii_formatter_assert.svh =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication
`define I2A_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Field widths, format codes, character codes and digit helpers.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 8;
    localparam int DIG_W   = 4;
    localparam int NUM_DIG = 10;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [CHAR_W-1:0]  char_t;
    typedef logic [DIG_W-1:0]   digit_t;
    typedef digit_t [NUM_DIG-1:0] digits_t;

    // Format kinds
    localparam kind_t KIND_CHAR = 2'd0;
    localparam kind_t KIND_UDEC = 2'd1;
    localparam kind_t KIND_SDEC = 2'd2;
    localparam kind_t KIND_HEX  = 2'd3;

    // Character codes
    localparam char_t ASC_ZERO  = 8'h30;
    localparam char_t ASC_A     = 8'h41;
    localparam char_t ASC_X     = 8'h78;
    localparam char_t ASC_MINUS = 8'h2D;
    localparam char_t ASC_SPACE = 8'h20;

    // Map a digit value to its uppercase glyph
    function automatic char_t glyph(input digit_t d);
        char_t g;
        if (d < digit_t'(10)) begin
            g = ASC_ZERO + char_t'(d);
        end
        else begin
            g = ASC_A + char_t'(d - digit_t'(10));
        end
        return g;
    endfunction

    // Add 3 to every decimal digit of 5 or more before the next shift
    function automatic digits_t dabble_adjust(input digits_t d);
        digits_t r;
        for (int i = 0; i < NUM_DIG; i++) begin
            r[i] = (d[i] >= digit_t'(5)) ? d[i] + digit_t'(3) : d[i];
        end
        return r;
    endfunction

    // True when every digit is a valid decimal digit
    function automatic logic digits_decimal(input digits_t d);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_DIG; i++) begin
            if (d[i] > digit_t'(9)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ===== sv/i2a_req_if.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: request channel
// Valid/ready channel carrying one format kind and one 32-bit word.
// ----------------------------------------------------------------------------
interface i2a_req_if
    import i2a_pkg::*;
    ;
    logic   valid;
    logic   ready;
    kind_t  kind;
    value_t value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

// ===== sv/i2a_res_if.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: character channel
// Valid/ready channel carrying one ASCII character and an end marker.
// ----------------------------------------------------------------------------
interface i2a_res_if
    import i2a_pkg::*;
    ;
    logic  valid;
    logic  ready;
    char_t character;
    logic  last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ===== sv/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Turns a 32-bit word into ASCII text: raw byte, unsigned or signed decimal,
// or 0x-prefixed uppercase hex with a trailing space.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a format kind and a 32-bit word; it is taken only while the
//   block is idle, so one request is in flight at a time.
//   res carries one ASCII character per transfer, most significant first,
//   with last set on the final character of the request (1 to 11 chars).
//   Decimal kinds run a bit-serial shift-and-add-3 converter over ten BCD
//   digits, one word bit per cycle. Hex and raw-byte requests skip it.
//   Leading zero digits are then dropped one per cycle (up to 9), the skip
//   state stops at the first digit, and each character is loaded into the
//   output register when the output slot is free.
//   A stalled receiver holds the current character in the output register
//   and holds the sequencer at its next output state; nothing is dropped.
//   Reset (rst_n low, asynchronous) returns to idle with res.valid low.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    i2a_req_if.sink      req,
    i2a_res_if.source    res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_PFX_ZERO,
        S_PFX_X,
        S_SKIP,
        S_DIGIT,
        S_SPACE,
        S_CHAR
    } state_t;

    localparam int CNT_W = $clog2(VALUE_W);
    localparam int IDX_W = $clog2(NUM_DIG);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);
    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(NUM_DIG - 1);
    localparam int HEX_DIG = VALUE_W / DIG_W;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic               neg_reg, neg_next;
    value_t             mag_reg, mag_next;
    digits_t            bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    char_t              out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    logic    slot;
    logic    accept;
    digits_t shifted;
    digits_t hex_digits;

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign res.valid     = out_valid_reg;
    assign res.character = out_char_reg;
    assign res.last      = out_last_reg;

    // Output slot is free when empty or being taken this cycle
    assign slot = !out_valid_reg || res.ready;

    // One double-dabble step: adjust, then shift in the next word bit
    assign shifted = digits_t'({dabble_adjust(bcd_reg), mag_reg[VALUE_W-1]});

    // Place hex nibbles in the low digits, top digits zero
    always_comb
    begin
        hex_digits = '0;
        for (int i = 0; i < HEX_DIG; i++) begin
            hex_digits[i] = req.value[i*DIG_W +: DIG_W];
        end
    end

    // Sequencer and output register next state
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    kind_next = req.kind;
                    idx_next  = IDX_TOP;
                    cnt_next  = '0;
                    neg_next  = (req.kind == KIND_SDEC) && req.value[VALUE_W-1];
                    mag_next  = ((req.kind == KIND_SDEC) && req.value[VALUE_W-1])
                                ? value_t'(0) - req.value : req.value;
                    bcd_next  = '0;
                    case (req.kind)
                        KIND_CHAR: state_next = S_CHAR;
                        KIND_HEX:
                        begin
                            bcd_next   = hex_digits;
                            state_next = S_PFX_ZERO;
                        end
                        default:   state_next = S_CONV;
                    endcase
                end
            end
            S_CONV:
            begin
                bcd_next = shifted;
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    state_next = neg_reg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN:
            begin
                if (slot) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASC_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = S_SKIP;
                end
            end
            S_PFX_ZERO:
            begin
                if (slot) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASC_ZERO;
                    out_last_next  = 1'b0;
                    state_next     = S_PFX_X;
                end
            end
            S_PFX_X:
            begin
                if (slot) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASC_X;
                    out_last_next  = 1'b0;
                    state_next     = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // Drop leading zeros, keeping at least the lowest digit
                if ((bcd_reg[idx_reg] == digit_t'(0)) && (idx_reg != '0)) begin
                    idx_next = idx_reg - 1'b1;
                end
                else begin
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (slot) begin
                    out_valid_next = 1'b1;
                    out_char_next  = glyph(bcd_reg[idx_reg]);
                    out_last_next  = (idx_reg == '0) && (kind_reg != KIND_HEX);
                    if (idx_reg == '0) begin
                        state_next = (kind_reg == KIND_HEX) ? S_SPACE : S_IDLE;
                    end
                    else begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            S_SPACE:
            begin
                if (slot) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ASC_SPACE;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_CHAR:
            begin
                if (slot) begin
                    out_valid_next = 1'b1;
                    out_char_next  = mag_reg[CHAR_W-1:0];
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            kind_reg      <= KIND_CHAR;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            bcd_reg       <= bcd_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
        end
    end

    // Converter finishes after exactly one pass over the word
    `I2A_ASSERT_NEXT(a_conv_ends, (state_reg == S_CONV) && (cnt_reg == CNT_LAST), state_reg != S_CONV, "conversion did not end after the last bit")
    // Shift-and-add-3 keeps every digit decimal
    `I2A_ASSERT_NOW(a_bcd_valid, (state_reg == S_CONV) || ((state_reg == S_DIGIT) && (kind_reg != KIND_HEX)), digits_decimal(bcd_reg), "BCD digit out of range")
    // Trailing space only follows hex output
    `I2A_ASSERT_NOW(a_space_hex, state_reg == S_SPACE, kind_reg == KIND_HEX, "space outside hex format")
    // Minus sign only for negative signed requests
    `I2A_ASSERT_NOW(a_sign_neg, state_reg == S_SIGN, neg_reg && (kind_reg == KIND_SDEC), "minus for non-negative request")

endmodule
